// File: rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Shared codes and constants of the pin record table.
// ----------------------------------------------------------------------------
package prt_pkg;

	localparam int TABLE_DEPTH_DEF    = 1024;
	localparam int OBJECT_BUCKETS_DEF = 8192;
	localparam int OWNER_BUCKETS_DEF  = 256;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_OBJ = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_OWN = 1'd1;

	localparam logic [CFG_W-1:0] MAX_OBJ_RST = 11'd64;
	localparam logic [CFG_W-1:0] MAX_OWN_RST = 11'd256;

	localparam logic [2:0] REQ_PIN       = 3'd0;
	localparam logic [2:0] REQ_CLONE     = 3'd1;
	localparam logic [2:0] REQ_RELEASE   = 3'd2;
	localparam logic [2:0] REQ_CNT_HANDLE = 3'd3;
	localparam logic [2:0] REQ_CNT_OWNER = 3'd4;
	localparam logic [2:0] REQ_CLEANUP   = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [2:0] PHASE_ACTIVE = 3'd3;

	localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;

	localparam logic [10:0] CNT_MAX = 11'd2047;

endpackage

// File: rtl/prt_req_if.sv
// ----------------------------------------------------------------------------
// prt_req_if
// Request channel of the pin record table.
// ----------------------------------------------------------------------------
interface prt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [63:0] handle_off;
	logic [31:0] handle_gen;
	logic [31:0] handle_region;
	logic [63:0] owner_node;
	logic [63:0] owner_process;
	logic [63:0] owner_incarnation;
	logic [63:0] owner_start_time;
	logic [9:0]  token_index;
	logic [63:0] token_state;

	modport source (output valid, req_type, handle_off, handle_gen,
		handle_region, owner_node, owner_process, owner_incarnation,
		owner_start_time, token_index, token_state, input ready);
	modport sink (input valid, req_type, handle_off, handle_gen,
		handle_region, owner_node, owner_process, owner_incarnation,
		owner_start_time, token_index, token_state, output ready);
endinterface

// File: rtl/prt_rsp_if.sv
// ----------------------------------------------------------------------------
// prt_rsp_if
// Result channel of the pin record table.
// ----------------------------------------------------------------------------
interface prt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [9:0]  out_index;
	logic [63:0] out_token;
	logic [10:0] pin_count;

	modport source (output valid, status, out_index, out_token, pin_count,
		input ready);
	modport sink (input valid, status, out_index, out_token, pin_count,
		output ready);
endinterface

// File: rtl/prt_ram.sv
// ----------------------------------------------------------------------------
// prt_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module prt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/pin_record_table_with_quotas.sv
// ----------------------------------------------------------------------------
// pin_record_table_with_quotas
// Table of pin records with per-object and per-owner quota buckets.
//
// Requests enter on req and one result item per request leaves on rsp, both
// valid/ready channels. Quota limits are to be written through cfg_we,
// cfg_index and cfg_data while no request is in flight; the block does not
// enforce this. One request is worked at a time by a sequencer around a
// single 32x32 multiplier and the record memories; req is ready only while
// the block is idle, so the next item can be taken in the cycle after a
// result is loaded. Pin runs an epoch step, nine mixes and a linear probe
// of records, then a quota check and a result step; clone first looks up
// its token. Release looks up the token, then clears the record and lowers
// its quota counts. Counting and cleanup walk the whole table, with a further
// read and write per cleaned record. A rejected epoch goes straight to the result.
// The table and bucket depths are powers of two; buckets are low hash bits.
// After reset a clearing pass over max(TABLE_DEPTH, OBJECT_BUCKETS,
// OWNER_BUCKETS) addresses zeroes every memory; req is not ready until it ends.
// A finished result sits in an output register, so the next request is
// accepted while the receiver stalls; a second result waits until the
// first is taken.
// ----------------------------------------------------------------------------
module pin_record_table_with_quotas
	import prt_pkg::*;
#(
	parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
	parameter int OBJECT_BUCKETS = OBJECT_BUCKETS_DEF,
	parameter int OWNER_BUCKETS  = OWNER_BUCKETS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	prt_req_if.sink              req,
	prt_rsp_if.source            rsp
);
	localparam int TIW   = $clog2(TABLE_DEPTH);
	localparam int OBW   = $clog2(OBJECT_BUCKETS);
	localparam int WBW   = $clog2(OWNER_BUCKETS);
	localparam int DW    = TIW + 1;
	localparam int CLR_A = (TABLE_DEPTH > OBJECT_BUCKETS) ? TABLE_DEPTH : OBJECT_BUCKETS;
	localparam int CLR_N = (CLR_A > OWNER_BUCKETS) ? CLR_A : OWNER_BUCKETS;
	localparam int CW    = $clog2(CLR_N) + 1;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_ACQ, S_HASH, S_PRB_RD, S_PRB_CK, S_QCK,
		S_LK_RD, S_LK_CK, S_REL_RD, S_REL_WR, S_SC_RD, S_SC_CK, S_CL_RD,
		S_CL_WR, S_DONE
	} state_t;

	state_t state_q;

	logic [CW-1:0]    clr_q;
	logic [CFG_W-1:0] max_obj_q, max_own_q;
	logic [63:0]      epoch_q, ep_q;

	logic [2:0]   req_q;
	logic [63:0]  off_q, gr_q, tstate_q;
	logic [255:0] own_q;

	logic [TIW-1:0] idx_q;
	logic [DW-1:0]  d_q;
	logic [OBW-1:0] ob_q;
	logic [WBW-1:0] wb_q;

	logic [3:0]  mstep_q, hk_q;
	logic [63:0] mv_q, prod_q, acc_q, hh_q, oh_q;

	logic [1:0]  res_st_q;
	logic [63:0] res_tok_q;
	logic [10:0] res_cnt_q;
	logic [TIW-1:0] res_idx_q;

	logic        ov_q;
	logic [1:0]  o_st_q;
	logic [9:0]  o_idx_q;
	logic [63:0] o_tok_q;
	logic [10:0] o_cnt_q;

	// Memory ports.
	logic [TIW-1:0] rec_wa;
	logic [OBW-1:0] obj_wa;
	logic [WBW-1:0] own_wa;
	logic st_we, rec_we, obj_we, ownq_we;
	logic [63:0] st_wd;
	logic [10:0] obj_wd, ownq_wd;
	logic [63:0] st_rd, off_rd, gr_rd;
	logic [255:0] own_rd;
	logic [OBW+WBW-1:0] bkt_rd;
	logic [10:0] obj_rd, ownq_rd;

	// Shared multiplier and mixing.
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p, cst, mix_in, mix_r;

	logic rec_live, hmatch, omatch, scan_hit, last_rec;
	logic [10:0] cnt_inc;

	always_comb begin
		cst   = (mstep_q < 4'd4) ? MIX_C1 : MIX_C2;
		mul_a = (mstep_q == 4'd3 || mstep_q == 4'd7) ? mv_q[63:32] : mv_q[31:0];
		mul_b = (mstep_q == 4'd2 || mstep_q == 4'd6) ? cst[63:32] : cst[31:0];
		mul_p = 64'(mul_a) * 64'(mul_b);
		mix_r = prod_q ^ (prod_q >> 31);
		case (hk_q)
			4'd0: mix_in = off_q;
			4'd1: mix_in = gr_q;
			4'd3: mix_in = own_q[63:0];
			4'd4: mix_in = own_q[127:64];
			4'd5: mix_in = own_q[191:128];
			4'd6: mix_in = own_q[255:192];
			4'd8: mix_in = hh_q ^ oh_q ^ ep_q;
			default: mix_in = acc_q;
		endcase
	end

	always_comb begin
		rec_live = (st_rd != 64'd0);
		hmatch   = (off_rd == off_q) && (gr_rd == gr_q);
		omatch   = (own_rd == own_q);
		scan_hit = rec_live && ((req_q == REQ_CNT_HANDLE) ? hmatch : omatch);
		last_rec = (idx_q == TIW'(TABLE_DEPTH - 1));
		cnt_inc  = (res_cnt_q == CNT_MAX) ? res_cnt_q : res_cnt_q + 11'd1;
	end

	always_comb begin
		rec_wa  = idx_q;
		obj_wa  = ob_q;
		own_wa  = wb_q;
		st_we   = 1'b0;
		rec_we  = 1'b0;
		obj_we  = 1'b0;
		ownq_we = 1'b0;
		st_wd   = 64'd0;
		obj_wd  = (obj_rd == 11'd0) ? 11'd0 : obj_rd - 11'd1;
		ownq_wd = (ownq_rd == 11'd0) ? 11'd0 : ownq_rd - 11'd1;
		if (state_q == S_CLEAR) begin
			rec_wa  = clr_q[TIW-1:0];
			obj_wa  = clr_q[OBW-1:0];
			own_wa  = clr_q[WBW-1:0];
			st_we   = clr_q < CW'(TABLE_DEPTH);
			rec_we  = clr_q < CW'(TABLE_DEPTH);
			obj_we  = clr_q < CW'(OBJECT_BUCKETS);
			ownq_we = clr_q < CW'(OWNER_BUCKETS);
			obj_wd  = 11'd0;
			ownq_wd = 11'd0;
		end else if (state_q == S_PRB_CK) begin
			rec_we = !rec_live;
		end else if (state_q == S_QCK) begin
			if (obj_rd < max_obj_q && ownq_rd < max_own_q) begin
				st_we   = 1'b1;
				obj_we  = 1'b1;
				ownq_we = 1'b1;
				st_wd   = {ep_q[60:0], PHASE_ACTIVE};
				obj_wd  = obj_rd + 11'd1;
				ownq_wd = ownq_rd + 11'd1;
			end
		end else if (state_q == S_REL_WR || state_q == S_CL_WR) begin
			st_we   = 1'b1;
			obj_we  = 1'b1;
			ownq_we = 1'b1;
		end
	end

	prt_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_st_ram (
		.clk, .we(st_we), .waddr(rec_wa), .wdata(st_wd), .raddr(idx_q), .rdata(st_rd));
	prt_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_off_ram (
		.clk, .we(rec_we), .waddr(rec_wa), .wdata((state_q == S_CLEAR) ? 64'd0 : off_q),
		.raddr(idx_q), .rdata(off_rd));
	prt_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_gr_ram (
		.clk, .we(rec_we), .waddr(rec_wa), .wdata((state_q == S_CLEAR) ? 64'd0 : gr_q),
		.raddr(idx_q), .rdata(gr_rd));
	prt_ram #(.WIDTH(256), .DEPTH(TABLE_DEPTH)) u_own_ram (
		.clk, .we(rec_we), .waddr(rec_wa), .wdata((state_q == S_CLEAR) ? 256'd0 : own_q),
		.raddr(idx_q), .rdata(own_rd));
	prt_ram #(.WIDTH(OBW+WBW), .DEPTH(TABLE_DEPTH)) u_bkt_ram (
		.clk, .we(rec_we), .waddr(rec_wa),
		.wdata((state_q == S_CLEAR) ? (OBW+WBW)'(0) : {wb_q, ob_q}),
		.raddr(idx_q), .rdata(bkt_rd));
	prt_ram #(.WIDTH(11), .DEPTH(OBJECT_BUCKETS)) u_objq_ram (
		.clk, .we(obj_we), .waddr(obj_wa), .wdata(obj_wd), .raddr(ob_q), .rdata(obj_rd));
	prt_ram #(.WIDTH(11), .DEPTH(OWNER_BUCKETS)) u_ownq_ram (
		.clk, .we(ownq_we), .waddr(own_wa), .wdata(ownq_wd), .raddr(wb_q), .rdata(ownq_rd));

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = ov_q;
	assign rsp.status    = o_st_q;
	assign rsp.out_index = o_idx_q;
	assign rsp.out_token = o_tok_q;
	assign rsp.pin_count = o_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			max_obj_q <= MAX_OBJ_RST;
			max_own_q <= MAX_OWN_RST;
			epoch_q   <= 64'd1;
			ov_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MAX_OBJ: max_obj_q <= cfg_data;
					CFG_MAX_OWN: max_own_q <= cfg_data;
					default: ;
				endcase
			end
			if (ov_q && rsp.ready && state_q != S_DONE) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(CLR_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						req_q     <= req.req_type;
						off_q     <= req.handle_off;
						gr_q      <= {req.handle_region, req.handle_gen};
						own_q     <= {req.owner_start_time, req.owner_incarnation,
							req.owner_process, req.owner_node};
						tstate_q  <= req.token_state;
						res_st_q  <= ST_NOT_FOUND;
						res_idx_q <= '0;
						res_tok_q <= 64'd0;
						res_cnt_q <= 11'd0;
						idx_q     <= TIW'(req.token_index);
						case (req.req_type) inside
							REQ_PIN: state_q <= S_ACQ;
							REQ_CLONE, REQ_RELEASE: begin
								state_q <= (32'(req.token_index) < 32'(TABLE_DEPTH)) ?
									S_LK_RD : S_DONE;
							end
							REQ_CNT_HANDLE, REQ_CNT_OWNER, REQ_CLEANUP: begin
								idx_q    <= '0;
								res_st_q <= ST_OK;
								state_q  <= S_SC_RD;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_ACQ: begin
					ep_q    <= epoch_q;
					epoch_q <= epoch_q + 64'd1;
					hk_q    <= 4'd0;
					mstep_q <= 4'd0;
					if (epoch_q == 64'd0 || epoch_q[63:61] != 3'd0) begin
						res_st_q <= ST_EXHAUSTED;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					mstep_q <= mstep_q + 4'd1;
					case (mstep_q) inside
						4'd0: mv_q <= mix_in ^ (mix_in >> 30);
						4'd1, 4'd5: prod_q <= mul_p;
						4'd2, 4'd3, 4'd6, 4'd7:
							prod_q[63:32] <= prod_q[63:32] + mul_p[31:0];
						4'd4: mv_q <= prod_q ^ (prod_q >> 27);
						default: begin
							mstep_q <= 4'd0;
							hk_q    <= hk_q + 4'd1;
							case (hk_q) inside
								4'd0, 4'd3: acc_q <= mix_r;
								4'd2: hh_q <= mix_r;
								4'd7: oh_q <= mix_r;
								4'd8: begin
									idx_q   <= mix_r[TIW-1:0];
									ob_q    <= hh_q[OBW-1:0];
									wb_q    <= oh_q[WBW-1:0];
									d_q     <= '0;
									state_q <= S_PRB_RD;
								end
								default: acc_q <= acc_q ^ mix_r;
							endcase
						end
					endcase
				end
				S_PRB_RD: state_q <= S_PRB_CK;
				S_PRB_CK: begin
					if (!rec_live) begin
						state_q <= S_QCK;
					end else if (d_q == DW'(TABLE_DEPTH - 1)) begin
						res_st_q <= ST_EXHAUSTED;
						state_q  <= S_DONE;
					end else begin
						d_q     <= d_q + DW'(1);
						idx_q   <= last_rec ? '0 : idx_q + TIW'(1);
						state_q <= S_PRB_RD;
					end
				end
				S_QCK: begin
					if (obj_rd < max_obj_q && ownq_rd < max_own_q) begin
						res_st_q  <= ST_OK;
						res_idx_q <= idx_q;
						res_tok_q <= {ep_q[60:0], PHASE_ACTIVE};
					end else begin
						res_st_q <= ST_EXHAUSTED;
					end
					state_q <= S_DONE;
				end
				S_LK_RD: state_q <= S_LK_CK;
				S_LK_CK: begin
					ob_q <= bkt_rd[OBW-1:0];
					wb_q <= bkt_rd[OBW+WBW-1:OBW];
					if (st_rd == tstate_q && hmatch && omatch) begin
						if (req_q == REQ_CLONE) begin
							state_q <= S_ACQ;
						end else if (tstate_q[2:0] == PHASE_ACTIVE) begin
							state_q <= S_REL_RD;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_REL_RD: state_q <= S_REL_WR;
				S_REL_WR: begin
					res_st_q <= ST_OK;
					state_q  <= S_DONE;
				end
				S_SC_RD: state_q <= S_SC_CK;
				S_SC_CK: begin
					ob_q <= bkt_rd[OBW-1:0];
					wb_q <= bkt_rd[OBW+WBW-1:OBW];
					if (scan_hit) begin
						res_cnt_q <= cnt_inc;
					end
					if (scan_hit && req_q == REQ_CLEANUP) begin
						state_q <= S_CL_RD;
					end else if (last_rec) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + TIW'(1);
						state_q <= S_SC_RD;
					end
				end
				S_CL_RD: state_q <= S_CL_WR;
				S_CL_WR: begin
					if (last_rec) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + TIW'(1);
						state_q <= S_SC_RD;
					end
				end
				S_DONE: begin
					if (!ov_q || rsp.ready) begin
						ov_q    <= 1'b1;
						o_st_q  <= res_st_q;
						o_idx_q <= 10'(res_idx_q);
						o_tok_q <= res_tok_q;
						o_cnt_q <= res_cnt_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while a request is in progress");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !req.ready)
		else $error("request taken during the clearing pass");

	a_token_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_OK && rsp.out_token != 64'd0
		|-> rsp.out_token[2:0] == PHASE_ACTIVE)
		else $error("new token without the active phase");

	a_pow2_depths: assert property (@(posedge clk) disable iff (!arst_n)
		(TABLE_DEPTH == (1 << TIW)) && (OBJECT_BUCKETS == (1 << OBW)) &&
		(OWNER_BUCKETS == (1 << WBW)))
		else $error("table and bucket depths must be powers of two");

endmodule
